// ===== design/nprs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NAND page read sequencer package
// Shared widths, request and bus action codes, flash opcodes and the
// address byte selection used by the sequencer and its channels.
// ----------------------------------------------------------------------------
package nprs_pkg;

    // Field widths
    localparam int ADDR_W   = 28;
    localparam int COUNT_W  = 29;
    localparam int CMD_W    = 2;
    localparam int ACT_W    = 3;
    localparam int BYTE_W   = 8;

    // Flash geometry
    localparam int PAGE_BYTES         = 2048;
    localparam int PAGE_ADDRESS_BYTES = 3;
    localparam int COL_BITS           = $clog2(PAGE_BYTES);
    localparam int PAGE_BITS          = ADDR_W - COL_BITS;
    localparam int ADDR_BYTES         = 2 + PAGE_ADDRESS_BYTES;
    localparam int ADDR_IDX_W         = 3;

    typedef logic [CMD_W-1:0]   cmd_t;
    typedef logic [ACT_W-1:0]   act_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [ADDR_IDX_W-1:0] addr_idx_t;

    // Request codes
    localparam cmd_t CMD_READ  = 2'd0;
    localparam cmd_t CMD_RESET = 2'd1;
    localparam cmd_t CMD_TICK  = 2'd2;

    // Bus action codes
    localparam act_t ACT_IDLE   = 3'd0;
    localparam act_t ACT_SELECT = 3'd1;
    localparam act_t ACT_CMD    = 3'd2;
    localparam act_t ACT_ADDR   = 3'd3;
    localparam act_t ACT_WAIT   = 3'd4;
    localparam act_t ACT_READ   = 3'd5;
    localparam act_t ACT_DESEL  = 3'd6;

    // Flash opcodes
    localparam byte_t OP_READ_1 = 8'h00;
    localparam byte_t OP_READ_2 = 8'h30;
    localparam byte_t OP_RESET  = 8'hff;

    // Pick one address cycle byte: column low, column high, page low..high
    function automatic byte_t address_byte(input addr_t addr, input addr_idx_t idx);
        logic [15:0] col;
        logic [23:0] page;
        logic [39:0] all;
        byte_t       res;
        col  = 16'(addr[COL_BITS-1:0]);
        page = 24'(addr[ADDR_W-1:COL_BITS]);
        all  = {page, col};
        res  = '0;
        if (idx < 3'd5)
        begin
            res = all[idx*8 +: 8];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== design/nprs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NAND page read sequencer channels
// Valid/ready channels for request items and bus action results.
// ----------------------------------------------------------------------------
interface nprs_item_if
    import nprs_pkg::*;
();
    logic   valid;
    logic   ready;
    cmd_t   command;
    addr_t  start_address;
    count_t byte_count;
    logic   ready_req;
    byte_t  flash_byte;

    modport source (output valid, command, start_address, byte_count, ready_req,
                    flash_byte, input ready);
    modport sink   (input valid, command, start_address, byte_count, ready_req,
                    flash_byte, output ready);
endinterface

interface nprs_result_if
    import nprs_pkg::*;
();
    logic  valid;
    logic  ready;
    act_t  bus_action;
    byte_t bus_byte;
    byte_t read_byte;
    logic  read_valid;
    logic  read_last;
    logic  engine_busy;

    modport source (output valid, bus_action, bus_byte, read_byte, read_valid,
                    read_last, engine_busy, input ready);
    modport sink   (input valid, bus_action, bus_byte, read_byte, read_valid,
                    read_last, engine_busy, output ready);
endinterface
`default_nettype wire

// ===== design/nand_page_read_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NAND page read sequencer
// Steps a large-page NAND flash bus through read and reset sequences, one
// bus action per transfer on the item channel.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one transfer per flash interface tick or request start. A read
//            request carries start_address and byte_count, a reset request
//            needs no payload, a tick carries ready_req and flash_byte.
//   result : exactly one transfer per item, giving the bus action to drive,
//            the command/address byte, any captured data byte with its
//            last flag, and whether the engine is still busy.
//   The result of an item is registered and sits in the output register
//   the cycle after its transfer. Throughput is one item per cycle while
//   results are taken; the single result register is the only storage
//   between the channels. A stalled result holds the register and drops
//   item ready until the result transfers; a result taken in the same
//   cycle frees the slot for the next item at once.
//   Reset returns the engine to idle with no result pending.
// ----------------------------------------------------------------------------
module nand_page_read_sequencer
    import nprs_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    nprs_item_if.sink          item,
    nprs_result_if.source      result
);

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_CMD1  = 4'd1;
    localparam logic [3:0] PH_ADDR  = 4'd2;
    localparam logic [3:0] PH_CMD2  = 4'd3;
    localparam logic [3:0] PH_WAIT  = 4'd4;
    localparam logic [3:0] PH_DATA  = 4'd5;
    localparam logic [3:0] PH_DESEL = 4'd6;
    localparam logic [3:0] PH_RCMD  = 4'd7;

    localparam addr_idx_t ADDR_IDX_LAST = ADDR_IDX_W'(ADDR_BYTES - 1);

    logic [3:0] phase_reg, phase_next;
    addr_idx_t  addr_idx_reg, addr_idx_next;
    addr_t      cur_addr_reg, cur_addr_next;
    count_t     remaining_reg, remaining_next;
    logic       is_reset_reg, is_reset_next;

    logic       out_valid_reg;
    act_t       act_reg, act_next;
    byte_t      bus_byte_reg, bus_byte_next;
    byte_t      rd_byte_reg, rd_byte_next;
    logic       rd_valid_reg, rd_valid_next;
    logic       rd_last_reg, rd_last_next;
    logic       busy_reg;

    logic       take;
    addr_t      addr_inc;
    count_t     remaining_dec;

    // Accept whenever the result slot is empty or emptying
    assign item.ready = !out_valid_reg || result.ready;
    assign take       = item.valid && item.ready;

    assign addr_inc      = cur_addr_reg + addr_t'(1);
    assign remaining_dec = remaining_reg - count_t'(1);

    // Advance the sequence by one bus action
    always_comb
    begin
        phase_next     = phase_reg;
        addr_idx_next  = addr_idx_reg;
        cur_addr_next  = cur_addr_reg;
        remaining_next = remaining_reg;
        is_reset_next  = is_reset_reg;
        act_next       = ACT_IDLE;
        bus_byte_next  = '0;
        rd_byte_next   = '0;
        rd_valid_next  = 1'b0;
        rd_last_next   = 1'b0;

        unique case (item.command)
            CMD_READ, CMD_RESET:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    act_next      = ACT_SELECT;
                    addr_idx_next = '0;
                    if (item.command == CMD_READ)
                    begin
                        is_reset_next  = 1'b0;
                        cur_addr_next  = item.start_address;
                        remaining_next = item.byte_count;
                        phase_next     = (item.byte_count == '0) ? PH_DESEL : PH_CMD1;
                    end
                    else
                    begin
                        is_reset_next = 1'b1;
                        phase_next    = PH_RCMD;
                    end
                end
            end
            CMD_TICK:
            begin
                unique case (phase_reg)
                    PH_CMD1:
                    begin
                        act_next      = ACT_CMD;
                        bus_byte_next = OP_READ_1;
                        addr_idx_next = '0;
                        phase_next    = PH_ADDR;
                    end
                    PH_ADDR:
                    begin
                        act_next      = ACT_ADDR;
                        bus_byte_next = address_byte(cur_addr_reg, addr_idx_reg);
                        if (addr_idx_reg >= ADDR_IDX_LAST)
                        begin
                            addr_idx_next = '0;
                            phase_next    = PH_CMD2;
                        end
                        else
                        begin
                            addr_idx_next = addr_idx_reg + addr_idx_t'(1);
                        end
                    end
                    PH_CMD2:
                    begin
                        act_next      = ACT_CMD;
                        bus_byte_next = OP_READ_2;
                        phase_next    = PH_WAIT;
                    end
                    PH_RCMD:
                    begin
                        act_next      = ACT_CMD;
                        bus_byte_next = OP_RESET;
                        phase_next    = PH_WAIT;
                    end
                    PH_WAIT:
                    begin
                        act_next = ACT_WAIT;
                        if (item.ready_req)
                        begin
                            phase_next = is_reset_reg ? PH_DESEL : PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        act_next       = ACT_READ;
                        rd_byte_next   = item.flash_byte;
                        rd_valid_next  = 1'b1;
                        cur_addr_next  = addr_inc;
                        remaining_next = remaining_dec;
                        if (remaining_dec == '0)
                        begin
                            rd_last_next = 1'b1;
                            phase_next   = PH_DESEL;
                        end
                        else if (addr_inc[COL_BITS-1:0] == '0)
                        begin
                            phase_next = PH_CMD1;
                        end
                    end
                    PH_DESEL:
                    begin
                        act_next      = ACT_DESEL;
                        is_reset_next = 1'b0;
                        phase_next    = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            default:
            begin
                act_next = ACT_IDLE;
            end
        endcase
    end

    // Hold the sequence state, update on each item transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            addr_idx_reg  <= '0;
            cur_addr_reg  <= '0;
            remaining_reg <= '0;
            is_reset_reg  <= 1'b0;
        end
        else if (take)
        begin
            phase_reg     <= phase_next;
            addr_idx_reg  <= addr_idx_next;
            cur_addr_reg  <= cur_addr_next;
            remaining_reg <= remaining_next;
            is_reset_reg  <= is_reset_next;
        end
    end

    // Track result occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            act_reg      <= act_next;
            bus_byte_reg <= bus_byte_next;
            rd_byte_reg  <= rd_byte_next;
            rd_valid_reg <= rd_valid_next;
            rd_last_reg  <= rd_last_next;
            busy_reg     <= (phase_next != PH_IDLE);
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.bus_action  = act_reg;
    assign result.bus_byte    = bus_byte_reg;
    assign result.read_byte   = rd_byte_reg;
    assign result.read_valid  = rd_valid_reg;
    assign result.read_last   = rd_last_reg;
    assign result.engine_busy = busy_reg;

endmodule
`default_nettype wire
